// ===== hw/rtl/ptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int ADDR_W   = 52;
  localparam int VA_W     = 48;
  localparam int ENTRY_W  = 64;
  localparam int IDX_W    = 9;
  localparam int LEVEL_W  = 2;
  localparam int PSIZE_W  = 2;
  localparam int PAGE_SH  = 12;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [PSIZE_W-1:0] PSIZE_4K = 2'd0;
  localparam logic [PSIZE_W-1:0] PSIZE_2M = 2'd1;
  localparam logic [PSIZE_W-1:0] PSIZE_1G = 2'd2;

  localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

  localparam int PTE_P_BIT  = 0;
  localparam int PTE_PS_BIT = 7;

  typedef enum logic [1:0] {
    OP_READ,
    OP_FAULT,
    OP_DONE
  } walk_op_code_t;

  // addr: table base for OP_READ, masked entry bits for OP_DONE
  typedef struct packed {
    walk_op_code_t        op;
    logic [ADDR_W-1:0]    addr;
    logic [VA_W-1:0]      va;
    logic [LEVEL_W-1:0]   level;
    logic [PSIZE_W-1:0]   psize;
  } walk_op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptw_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_in_if
// Request channel: translate commands and returned table entries.
// ----------------------------------------------------------------------------
interface ptw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [ptw_pkg::ADDR_W-1:0]   root_table;
  logic [ptw_pkg::VA_W-1:0]     virtual_address;
  logic [ptw_pkg::ENTRY_W-1:0]  table_entry;

  modport source (output valid, output cmd, output root_table,
                  output virtual_address, output table_entry, input ready);
  modport sink   (input valid, input cmd, input root_table,
                  input virtual_address, input table_entry, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptw_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_out_if
// Result channel: memory read requests and finished translations.
// ----------------------------------------------------------------------------
interface ptw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ptw_pkg::ADDR_W-1:0]    read_address;
  logic [ptw_pkg::ADDR_W-1:0]    physical_address;
  logic                          fault;
  logic [ptw_pkg::PSIZE_W-1:0]   psize;

  modport source (output valid, output kind, output read_address,
                  output physical_address, output fault, output psize,
                  input ready);
  modport sink   (input valid, input kind, input read_address,
                  input physical_address, input fault, input psize,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_front
// Accepts requests, tracks walk state and classifies each transfer.
// ----------------------------------------------------------------------------
module ptw_front #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  ptw_in_if.sink               in_ch,
  input  wire logic            q_full,
  output ptw_pkg::walk_op_t    q_data,
  output logic                 q_push
);

  localparam logic [ptw_pkg::ADDR_W-1:0] PHYS_MASK =
    {ptw_pkg::ADDR_W{1'b1}} >> (ptw_pkg::ADDR_W - PHYS_ADDR_BITS);
  localparam logic [ptw_pkg::ADDR_W-1:0] FRAME_MASK =
    PHYS_MASK & ~((ptw_pkg::ADDR_W)'((1 << ptw_pkg::PAGE_SH) - 1));

  logic                           active_r, active_nxt;
  logic [ptw_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic [ptw_pkg::VA_W-1:0]       va_r, va_nxt;
  logic                           accept;
  logic [ptw_pkg::ADDR_W-1:0]     entry_bits;
  logic                           present;
  logic                           ps;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign entry_bits  = in_ch.table_entry[ptw_pkg::ADDR_W-1:0] & PHYS_MASK;
  assign present     = in_ch.table_entry[ptw_pkg::PTE_P_BIT];
  assign ps          = in_ch.table_entry[ptw_pkg::PTE_PS_BIT];

  always_comb begin
    active_nxt   = active_r;
    level_nxt    = level_r;
    va_nxt       = va_r;
    q_push       = 1'b0;
    q_data.op    = ptw_pkg::OP_READ;
    q_data.addr  = entry_bits;
    q_data.va    = va_r;
    q_data.level = level_r;
    q_data.psize = ptw_pkg::PSIZE_4K;
    if (accept) begin
      if (in_ch.cmd == ptw_pkg::CMD_START) begin
        active_nxt   = 1'b1;
        level_nxt    = ptw_pkg::LVL_PML4;
        va_nxt       = in_ch.virtual_address;
        q_push       = 1'b1;
        q_data.addr  = in_ch.root_table & FRAME_MASK;
        q_data.va    = in_ch.virtual_address;
        q_data.level = ptw_pkg::LVL_PML4;
      end else if (active_r) begin
        q_push = 1'b1;
        if (!present) begin
          active_nxt = 1'b0;
          level_nxt  = ptw_pkg::LVL_PML4;
          q_data.op  = ptw_pkg::OP_FAULT;
        end else if (level_r == ptw_pkg::LVL_PDPT && ps) begin
          active_nxt   = 1'b0;
          level_nxt    = ptw_pkg::LVL_PML4;
          q_data.op    = ptw_pkg::OP_DONE;
          q_data.psize = ptw_pkg::PSIZE_1G;
        end else if (level_r == ptw_pkg::LVL_PD && ps) begin
          active_nxt   = 1'b0;
          level_nxt    = ptw_pkg::LVL_PML4;
          q_data.op    = ptw_pkg::OP_DONE;
          q_data.psize = ptw_pkg::PSIZE_2M;
        end else if (level_r == ptw_pkg::LVL_PT) begin
          active_nxt   = 1'b0;
          level_nxt    = ptw_pkg::LVL_PML4;
          q_data.op    = ptw_pkg::OP_DONE;
          q_data.psize = ptw_pkg::PSIZE_4K;
        end else begin
          level_nxt    = level_r + 2'd1;
          q_data.addr  = entry_bits & FRAME_MASK;
          q_data.level = level_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      level_r  <= ptw_pkg::LVL_PML4;
      va_r     <= '0;
    end else begin
      active_r <= active_nxt;
      level_r  <= level_nxt;
      va_r     <= va_nxt;
    end
  end

  a_start_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.cmd == ptw_pkg::CMD_START) |=>
      (active_r && level_r == ptw_pkg::LVL_PML4))
    else $error("start transfer did not open a walk at the top level");

  a_end_closes_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && (q_data.op == ptw_pkg::OP_FAULT || q_data.op == ptw_pkg::OP_DONE))
      |=> !active_r)
    else $error("walk still active after its final result");

endmodule
`default_nettype wire

// ===== hw/rtl/ptw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module ptw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ptw_pkg::walk_op_t  push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output ptw_pkg::walk_op_t       head_data
);

  ptw_pkg::walk_op_t  mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/ptw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_back
// Forms read addresses and final translations into the output register.
// ----------------------------------------------------------------------------
module ptw_back #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire ptw_pkg::walk_op_t  head_data,
  output logic                    pop,
  ptw_out_if.source               out_ch
);

  localparam logic [ptw_pkg::ADDR_W-1:0] PHYS_MASK =
    {ptw_pkg::ADDR_W{1'b1}} >> (ptw_pkg::ADDR_W - PHYS_ADDR_BITS);
  localparam int PAD_W = ptw_pkg::ADDR_W - ptw_pkg::IDX_W - 3;

  logic                            valid_r;
  logic                            kind_r, kind_nxt;
  logic [ptw_pkg::ADDR_W-1:0]      raddr_r, raddr_nxt;
  logic [ptw_pkg::ADDR_W-1:0]      paddr_r, paddr_nxt;
  logic                            fault_r, fault_nxt;
  logic [ptw_pkg::PSIZE_W-1:0]     psize_r, psize_nxt;
  logic [ptw_pkg::IDX_W-1:0]       idx;
  logic [ptw_pkg::ADDR_W-1:0]      low_mask;
  logic [ptw_pkg::ADDR_W-1:0]      va_ext;

  assign pop    = head_valid && (!valid_r || out_ch.ready);
  assign va_ext = {{(ptw_pkg::ADDR_W - ptw_pkg::VA_W){1'b0}}, head_data.va};

  always_comb begin
    unique case (head_data.level)
      ptw_pkg::LVL_PML4: idx = head_data.va[47:39];
      ptw_pkg::LVL_PDPT: idx = head_data.va[38:30];
      ptw_pkg::LVL_PD:   idx = head_data.va[29:21];
      default:           idx = head_data.va[20:12];
    endcase
  end

  always_comb begin
    unique case (head_data.psize)
      ptw_pkg::PSIZE_1G: low_mask = (ptw_pkg::ADDR_W)'((64'd1 << 30) - 64'd1);
      ptw_pkg::PSIZE_2M: low_mask = (ptw_pkg::ADDR_W)'((64'd1 << 21) - 64'd1);
      default:           low_mask = (ptw_pkg::ADDR_W)'((64'd1 << 12) - 64'd1);
    endcase
  end

  always_comb begin
    kind_nxt  = ptw_pkg::KIND_READ;
    raddr_nxt = '0;
    paddr_nxt = '0;
    fault_nxt = 1'b0;
    psize_nxt = ptw_pkg::PSIZE_4K;
    unique case (head_data.op)
      ptw_pkg::OP_READ: begin
        raddr_nxt = head_data.addr + {{PAD_W{1'b0}}, idx, 3'b000};
      end
      ptw_pkg::OP_FAULT: begin
        kind_nxt  = ptw_pkg::KIND_DONE;
        fault_nxt = 1'b1;
      end
      ptw_pkg::OP_DONE: begin
        kind_nxt  = ptw_pkg::KIND_DONE;
        paddr_nxt = ((head_data.addr & ~low_mask) | (va_ext & low_mask)) & PHYS_MASK;
        psize_nxt = head_data.psize;
      end
      default: begin
        kind_nxt = ptw_pkg::KIND_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= kind_nxt;
      raddr_r <= raddr_nxt;
      paddr_r <= paddr_nxt;
      fault_r <= fault_nxt;
      psize_r <= psize_nxt;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.kind             = kind_r;
  assign out_ch.read_address     = raddr_r;
  assign out_ch.physical_address = paddr_r;
  assign out_ch.fault            = fault_r;
  assign out_ch.psize            = psize_r;

endmodule
`default_nettype wire

// ===== hw/rtl/four_level_page_table_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walker with decoupled classify and address stages.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a start command (root table, virtual address) or a table
//   entry returned from memory. out_ch carries either a read request for the
//   next 8-byte entry or a finished translation (physical address, fault,
//   page size). Each returned entry is fed back on in_ch by the user.
//   A start transfer produces one read request; an entry transfer produces a
//   read request or a final result; an entry with no walk open produces none.
//   out_ch.valid rises once the transfer has passed through the queue and
//   into the back stage's output register.
//   Throughput: one transfer per cycle while out_ch is ready, set by the
//   combinational front classifier and the registered address stage.
//   A two-entry queue sits between front and back and the back stage has an
//   output register; when out_ch stalls, in_ch keeps taking transfers until
//   the queue fills, then in_ch.ready drops.
//   Reset (rst_n low, synchronous) closes any open walk and empties the
//   queue and the output register.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptw_in_if.sink     in_ch,
  ptw_out_if.source  out_ch
);

  ptw_pkg::walk_op_t  q_push_data;
  ptw_pkg::walk_op_t  q_head_data;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_head_valid;

  ptw_front #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_data (q_push_data),
    .q_push (q_push)
  );

  ptw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  ptw_back #(
    .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
